### design/mpbp_pkg.sv
// ----------------------------------------------------------------------------
// mpbp_pkg
// Shared types and pattern tables for the multi-pattern byte patcher.
// ----------------------------------------------------------------------------
package mpbp_pkg;

  localparam int PAT_COUNT = 3;
  localparam int PAT_MAX   = 12;
  localparam int FLAG_W    = 3;

  localparam logic [FLAG_W-1:0] REQ_MASK_RESET = 3'h7;

  // One queued request: a stream byte and its end marker
  typedef struct packed {
    logic [7:0] data;
    logic       eos;
  } mpbp_item_t;

  localparam logic [4:0] PAT_LEN [PAT_COUNT] = '{5'd12, 5'd10, 5'd12};

  localparam logic [7:0] PAT_MATCH [PAT_COUNT][PAT_MAX] = '{
    '{8'h01, 8'h48, 8'h00, 8'h68, 8'h70, 8'h47, 8'hC0, 8'h46, 8'h68, 8'hFD, 8'hFF, 8'h02},
    '{8'h02, 8'h98, 8'h08, 8'h42, 8'h00, 8'hD1, 8'h00, 8'h22, 8'h00, 8'h2A, 8'h00, 8'h00},
    '{8'h01, 8'h48, 8'h00, 8'h7A, 8'h70, 8'h47, 8'hC0, 8'h46, 8'h68, 8'hFD, 8'hFF, 8'h02}
  };

  localparam logic [7:0] PAT_REPL [PAT_COUNT][PAT_MAX] = '{
    '{8'h01, 8'h4B, 8'h7F, 8'h20, 8'h18, 8'h60, 8'h70, 8'h47, 8'h68, 8'hFD, 8'hFF, 8'h02},
    '{8'h02, 8'h98, 8'h08, 8'h42, 8'hC0, 8'h46, 8'h01, 8'h22, 8'h00, 8'h2A, 8'h00, 8'h00},
    '{8'h01, 8'h4B, 8'h02, 8'h20, 8'h18, 8'h72, 8'h70, 8'h47, 8'h68, 8'hFD, 8'hFF, 8'h02}
  };

endpackage

### design/mpbp_front.sv
// ----------------------------------------------------------------------------
// mpbp_front
// Input side: accepts stream bytes and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module mpbp_front import mpbp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  mpbp_item_t item_i,
  output logic       item_valid_o,
  output mpbp_item_t item_o,
  input  logic       item_ready_i
);

  mpbp_item_t slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign in_ready_o   = (count_q != 2'd2);
  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = slot_q[rd_ptr_q];
  assign push         = in_valid_i & in_ready_o;
  assign pop          = item_valid_o & item_ready_i;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ pop;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the incoming request
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

### design/mpbp_back.sv
// ----------------------------------------------------------------------------
// mpbp_back
// Window, pattern match and patch, flag tracking and the output register.
// ----------------------------------------------------------------------------
module mpbp_back import mpbp_pkg::*; #(
  parameter int WindowLen   = 12,
  parameter int NumPatterns = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [FLAG_W-1:0] req_mask_i,
  input  logic              item_valid_i,
  input  mpbp_item_t        item_i,
  output logic              item_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              out_last_o,
  output logic [FLAG_W-1:0] found_flags_o,
  output logic              duplicate_seen_o,
  output logic              all_required_found_o
);

  localparam int FillW  = $clog2(WindowLen + 1);
  localparam int IdxW   = $clog2(WindowLen);
  localparam int ActPat = (NumPatterns < PAT_COUNT) ? NumPatterns : PAT_COUNT;

  localparam logic ST_FILL  = 1'b0;
  localparam logic ST_FLUSH = 1'b1;

  logic [7:0]        win_q [WindowLen];
  logic [7:0]        win_d [WindowLen];
  logic [7:0]        work  [WindowLen];
  logic [7:0]        patched [WindowLen];
  logic [FillW-1:0]  fill_q, fill_d, avail;
  logic              state_q, state_d;
  logic [FLAG_W-1:0] found_q, found_d, found_new;
  logic              dup_q, dup_d, dup_new;
  logic              space, pop, emit, last;

  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_byte_q;
  logic              out_last_q, out_dup_q, out_all_q;
  logic [FLAG_W-1:0] out_found_q;

  assign space        = !out_valid_q || out_ready_i;
  assign item_ready_o = (state_q == ST_FILL) && space;
  assign pop          = item_valid_i && item_ready_o;
  assign avail        = (state_q == ST_FILL) ? fill_q + FillW'(1) : fill_q;
  assign last         = (state_q == ST_FLUSH) && (fill_q == FillW'(1));

  // Decide whether a byte leaves the window this cycle
  always_comb begin
    if (state_q == ST_FLUSH) begin
      emit = space;
    end else begin
      emit = pop && !item_i.eos && (fill_q == FillW'(WindowLen - 1));
    end
  end

  // Build the window as seen after the incoming byte is appended
  always_comb begin
    for (int i = 0; i < WindowLen; i++) begin
      if (state_q == ST_FILL && fill_q[IdxW-1:0] == IdxW'(i)) begin
        work[i] = item_i.data;
      end else begin
        work[i] = win_q[i];
      end
    end
  end

  // Test patterns in table order, patching the window on each hit
  always_comb begin
    logic hit;
    for (int i = 0; i < WindowLen; i++) begin
      patched[i] = work[i];
    end
    found_new = found_q;
    dup_new   = dup_q;
    for (int k = 0; k < ActPat; k++) begin
      hit = (int'(PAT_LEN[k]) <= WindowLen) && (int'(PAT_LEN[k]) <= int'(avail));
      for (int i = 0; i < WindowLen && i < PAT_MAX; i++) begin
        if (i < int'(PAT_LEN[k]) && patched[i] != PAT_MATCH[k][i]) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        if (found_new[k]) begin
          dup_new = 1'b1;
        end
        found_new[k] = 1'b1;
        for (int i = 0; i < WindowLen && i < PAT_MAX; i++) begin
          if (i < int'(PAT_LEN[k])) begin
            patched[i] = PAT_REPL[k][i];
          end
        end
      end
    end
  end

  // Next window, fill level, flags and state
  always_comb begin
    for (int i = 0; i < WindowLen; i++) begin
      win_d[i] = win_q[i];
    end
    fill_d  = fill_q;
    found_d = found_q;
    dup_d   = dup_q;
    state_d = state_q;
    if (emit) begin
      for (int i = 0; i < WindowLen - 1; i++) begin
        win_d[i] = patched[i + 1];
      end
      win_d[WindowLen-1] = patched[WindowLen-1];
      found_d = found_new;
      dup_d   = dup_new;
      if (state_q == ST_FLUSH) begin
        fill_d = fill_q - FillW'(1);
        if (last) begin
          state_d = ST_FILL;
          found_d = '0;
          dup_d   = 1'b0;
        end
      end
    end else if (pop) begin
      for (int i = 0; i < WindowLen; i++) begin
        win_d[i] = work[i];
      end
      fill_d = fill_q + FillW'(1);
      if (item_i.eos) begin
        state_d = ST_FLUSH;
      end
    end
  end

  assign out_valid_d = emit || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      found_q     <= '0;
      dup_q       <= 1'b0;
      state_q     <= ST_FILL;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      found_q     <= found_d;
      dup_q       <= dup_d;
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold window bytes and the outgoing result
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < WindowLen; i++) begin
      win_q[i] <= win_d[i];
    end
    if (emit) begin
      out_byte_q  <= patched[0];
      out_last_q  <= last;
      out_found_q <= found_new;
      out_dup_q   <= dup_new;
      out_all_q   <= ((found_new & req_mask_i) == req_mask_i);
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_byte_o           = out_byte_q;
  assign out_last_o           = out_last_q;
  assign found_flags_o        = out_found_q;
  assign duplicate_seen_o     = out_dup_q;
  assign all_required_found_o = out_all_q;

endmodule

### design/multi_pattern_byte_patcher.sv
// Path: a request passes the queue, then the window stage and output register.
// Throughput: one byte per cycle in steady state while the receiver keeps up;
// at end of stream the window drains one byte per cycle, again only while the
// receiver keeps up, and new input waits until the drain is done.
// Reset: rst_ni clears the queue, window fill, flags and sets required_mask to 7.
// ----------------------------------------------------------------------------
// multi_pattern_byte_patcher
// Streams bytes through a window, patches fixed byte patterns and reports flags.
// ----------------------------------------------------------------------------
module multi_pattern_byte_patcher import mpbp_pkg::*; #(
  parameter int WINDOW_LEN   = 12,
  parameter int NUM_PATTERNS = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [FLAG_W-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        data_byte_i,
  input  logic              end_of_stream_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              out_last_o,
  output logic [FLAG_W-1:0] found_flags_o,
  output logic              duplicate_seen_o,
  output logic              all_required_found_o
);

  logic [FLAG_W-1:0] req_mask_q;
  mpbp_item_t        in_item, q_item;
  logic              q_valid, q_ready;

  assign cfg_ready_o = 1'b1;

  // Hold the required-pattern mask
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_mask_q <= REQ_MASK_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      req_mask_q <= cfg_data_i;
    end
  end

  assign in_item.data = data_byte_i;
  assign in_item.eos  = end_of_stream_i;

  mpbp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .item_i       (in_item),
    .item_valid_o (q_valid),
    .item_o       (q_item),
    .item_ready_i (q_ready)
  );

  mpbp_back #(
    .WindowLen   (WINDOW_LEN),
    .NumPatterns (NUM_PATTERNS)
  ) u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .req_mask_i           (req_mask_q),
    .item_valid_i         (q_valid),
    .item_i               (q_item),
    .item_ready_o         (q_ready),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .out_byte_o           (out_byte_o),
    .out_last_o           (out_last_o),
    .found_flags_o        (found_flags_o),
    .duplicate_seen_o     (duplicate_seen_o),
    .all_required_found_o (all_required_found_o)
  );

endmodule

### sim/patch_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// patch_check_pkg
// Scoreboard for the byte patcher: predicts patched bytes and flags per request
// and checks each output byte against the oldest prediction.
// ----------------------------------------------------------------------------
package patch_check_pkg;

  localparam int WIN_BYTES = 12;
  localparam int SIG_COUNT = 3;
  localparam int SIG_MAX   = 12;

  // Search patterns and their replacements, table order
  localparam int SIG_LEN [SIG_COUNT] = '{12, 10, 12};

  localparam logic [7:0] SIG_BYTES [SIG_COUNT][SIG_MAX] = '{
    '{8'h01, 8'h48, 8'h00, 8'h68, 8'h70, 8'h47, 8'hC0, 8'h46, 8'h68, 8'hFD, 8'hFF, 8'h02},
    '{8'h02, 8'h98, 8'h08, 8'h42, 8'h00, 8'hD1, 8'h00, 8'h22, 8'h00, 8'h2A, 8'h00, 8'h00},
    '{8'h01, 8'h48, 8'h00, 8'h7A, 8'h70, 8'h47, 8'hC0, 8'h46, 8'h68, 8'hFD, 8'hFF, 8'h02}
  };

  localparam logic [7:0] FIX_BYTES [SIG_COUNT][SIG_MAX] = '{
    '{8'h01, 8'h4B, 8'h7F, 8'h20, 8'h18, 8'h60, 8'h70, 8'h47, 8'h68, 8'hFD, 8'hFF, 8'h02},
    '{8'h02, 8'h98, 8'h08, 8'h42, 8'hC0, 8'h46, 8'h01, 8'h22, 8'h00, 8'h2A, 8'h00, 8'h00},
    '{8'h01, 8'h4B, 8'h02, 8'h20, 8'h18, 8'h72, 8'h70, 8'h47, 8'h68, 8'hFD, 8'hFF, 8'h02}
  };

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [2:0] found;
    logic       dup;
    logic       all_req;
  } patched_byte_t;

  class patch_scoreboard;
    logic [7:0]    win [WIN_BYTES];
    int            fill;
    logic [2:0]    found_bits;
    logic          dup_bit;
    logic [2:0]    req_mask;
    patched_byte_t expected_q [$];
    int            mismatches;
    int            checked;
    int            hits [SIG_COUNT];
    int            dup_streams;
    int            streams;

    function new();
      fill        = 0;
      found_bits  = 3'b000;
      dup_bit     = 1'b0;
      req_mask    = 3'h7;
      mismatches  = 0;
      checked     = 0;
      dup_streams = 0;
      streams     = 0;
      foreach (hits[k]) hits[k] = 0;
      foreach (win[i]) win[i] = 8'h00;
    endfunction

    function void set_mask(logic [2:0] m);
      req_mask = m;
    endfunction

    // Try every pattern at the oldest position, on the possibly patched window
    function void patch_head();
      bit same;
      for (int k = 0; k < SIG_COUNT; k++) begin
        if (SIG_LEN[k] > fill || SIG_LEN[k] > WIN_BYTES) continue;
        same = 1'b1;
        for (int j = 0; j < SIG_LEN[k]; j++) begin
          if (win[j] != SIG_BYTES[k][j]) same = 1'b0;
        end
        if (!same) continue;
        if (found_bits[k]) dup_bit = 1'b1;
        found_bits[k] = 1'b1;
        hits[k]++;
        for (int j = 0; j < SIG_LEN[k]; j++) win[j] = FIX_BYTES[k][j];
      end
    endfunction

    // Queue the oldest byte with current flags, then shift the window
    function void emit_head(bit last);
      patched_byte_t r;
      r.data    = win[0];
      r.last    = last;
      r.found   = found_bits;
      r.dup     = dup_bit;
      r.all_req = ((found_bits & req_mask) == req_mask);
      expected_q.push_back(r);
      for (int i = 0; i < WIN_BYTES - 1; i++) win[i] = win[i + 1];
      fill--;
    endfunction

    // Predict the output bytes caused by one accepted request
    function void note_request(logic [7:0] d, logic eos);
      if (fill < WIN_BYTES) begin
        win[fill] = d;
        fill++;
      end
      if (!eos) begin
        if (fill >= WIN_BYTES) begin
          patch_head();
          emit_head(1'b0);
        end
      end else begin
        while (fill > 0) begin
          patch_head();
          emit_head(fill == 1);
        end
        streams++;
        if (dup_bit) dup_streams++;
        found_bits = 3'b000;
        dup_bit    = 1'b0;
      end
    endfunction

    // Compare one output byte with the oldest prediction
    function void check_result(logic [7:0] d, logic last, logic [2:0] found, logic dup,
                               logic all_req);
      patched_byte_t want;
      checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output byte %02h last %0b with nothing predicted", d, last);
        return;
      end
      want = expected_q.pop_front();
      if (want.data !== d || want.last !== last || want.found !== found ||
          want.dup !== dup || want.all_req !== all_req) begin
        mismatches++;
        if (mismatches <= 10)
          $display("output %0d: expected byte %02h last %0b found %03b dup %0b all %0b, got byte %02h last %0b found %03b dup %0b all %0b",
                   checked, want.data, want.last, want.found, want.dup, want.all_req,
                   d, last, found, dup, all_req);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams directed and random byte images through the patcher with random gaps
// on both sides, changes the required mask between streams and checks every
// output byte and flag against the scoreboard.
// ----------------------------------------------------------------------------
module testbench;
  import mpbp_pkg::*;
  import patch_check_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 80;
  localparam int RANDOM_ITEMS = 450;

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              cfg_valid_i     = 1'b0;
  logic              cfg_ready_o;
  logic [FLAG_W-1:0] cfg_data_i      = '0;
  logic              in_valid_i      = 1'b0;
  logic              in_ready_o;
  logic [7:0]        data_byte_i     = 8'h00;
  logic              end_of_stream_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i     = 1'b0;
  logic [7:0]        out_byte_o;
  logic              out_last_o;
  logic [FLAG_W-1:0] found_flags_o;
  logic              duplicate_seen_o;
  logic              all_required_found_o;

  patch_scoreboard sb = new();

  bit         no_idle    = 1'b0;
  bit         hold_req   = 1'b0;
  bit         hold_done  = 1'b0;
  int         items_sent = 0;
  int         cfg_writes = 0;
  int         directed_items;
  logic [7:0] stream_q [$];

  multi_pattern_byte_patcher #(
    .WINDOW_LEN  (12),
    .NUM_PATTERNS(3)
  ) dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .data_byte_i         (data_byte_i),
    .end_of_stream_i     (end_of_stream_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .out_byte_o          (out_byte_o),
    .out_last_o          (out_last_o),
    .found_flags_o       (found_flags_o),
    .duplicate_seen_o    (duplicate_seen_o),
    .all_required_found_o(all_required_found_o)
  );

  // Free-running clock, 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function int pick_gap();
    if (no_idle) return 0;
    return $urandom_range(0, 9);
  endfunction

  // Offer one request and hold it until accepted
  task send_byte(input logic [7:0] d, input logic eos);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    data_byte_i     <= d;
    end_of_stream_i <= eos;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(d, eos);
    items_sent++;
  endtask

  task send_stream();
    foreach (stream_q[i]) send_byte(stream_q[i], i == stream_q.size() - 1);
  endtask

  // Write the mask only once the block has drained
  task write_mask(input logic [FLAG_W-1:0] m);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_mask(m);
    cfg_writes++;
  endtask

  // Random bytes with whole, truncated or corrupted patterns planted in them
  task build_random_stream(input int len);
    int n_ins;
    int k;
    int off;
    stream_q.delete();
    for (int i = 0; i < len; i++) stream_q.push_back(8'($urandom_range(0, 255)));
    n_ins = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 3);
    for (int n = 0; n < n_ins; n++) begin
      k   = $urandom_range(0, SIG_COUNT - 1);
      off = $urandom_range(0, len - 1);
      for (int j = 0; j < SIG_LEN[k] && off + j < len; j++) stream_q[off + j] = SIG_BYTES[k][j];
      if ($urandom_range(0, 3) == 0) begin
        off = off + $urandom_range(0, SIG_LEN[k] - 1);
        if (off < len) stream_q[off] = stream_q[off] ^ 8'($urandom_range(1, 255));
      end
    end
  endtask

  // Receiver: random gaps, one long hold-off while a long stream is offered
  initial begin : receiver
    int gap;
    forever begin
      if (hold_req && !hold_done) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Check every accepted output byte
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(out_byte_o, out_last_o, found_flags_o, duplicate_seen_o,
                      all_required_found_o);
  end

  // Abort when no channel moves for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("timeout: no handshake for %0d cycles, %0d bytes still predicted",
             IDLE_LIMIT, sb.pending());
    $display("testbench: errors");
    $finish;
  end

  initial begin : main
    int len;
    int r;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single byte stream, flushed at once, with the reset mask
    stream_q = '{8'hFF};
    send_stream();

    // Short stream that is exactly the second pattern
    stream_q.delete();
    for (int j = 0; j < SIG_LEN[1]; j++) stream_q.push_back(SIG_BYTES[1][j]);
    send_stream();

    // First pattern cut short by end of stream: no match
    write_mask(3'h0);
    stream_q.delete();
    for (int j = 0; j < SIG_LEN[0] - 1; j++) stream_q.push_back(SIG_BYTES[0][j]);
    send_stream();

    write_mask(3'h7);
    stream_q = '{8'h00};
    send_stream();
    directed_items = items_sent;

    // Long stream against a stalled receiver to fill the block
    no_idle  = 1'b1;
    hold_req = 1'b1;
    build_random_stream(64);
    send_stream();
    no_idle = 1'b0;

    // Random streams, mostly carrying patterns
    while (items_sent < directed_items + RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) write_mask(FLAG_W'($urandom_range(0, 7)));
      no_idle = ($urandom_range(0, 5) == 0);
      r = $urandom_range(0, 9);
      if (r < 2)      len = $urandom_range(1, 11);
      else if (r < 8) len = $urandom_range(12, 30);
      else            len = $urandom_range(31, 60);
      build_random_stream(len);
      send_stream();
    end
    no_idle = 1'b0;

    // Drain and let the pipeline settle
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("ran %0d streams, %0d input bytes, %0d output bytes checked, %0d mask writes",
             sb.streams, items_sent, sb.checked, cfg_writes);
    $display("pattern hits %0d/%0d/%0d, streams with a repeated match %0d, mismatches %0d",
             sb.hits[0], sb.hits[1], sb.hits[2], sb.dup_streams, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
